// ===== rtl/core/tmb_pkg.sv =====
// tmb_pkg: shared constants, request and result codes, cell command types
// for the tick timer bank. No dependencies.
`default_nettype none

package tmb_pkg;

  // field widths
  localparam int REQ_W  = 2;
  localparam int ID_W   = 4;
  localparam int MS_W   = 16;
  localparam int LOOP_W = 16;
  localparam int RATE_W = 10;
  localparam int KIND_W = 2;

  // default sizes for the top level parameters
  localparam int NUM_TIMERS_DEF  = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  // tick rate after reset
  localparam logic [RATE_W-1:0] RATE_RST = 10'd60;

  // divide by 1000 through a reciprocal: floor(x * RECIP / 2^RECIP_SH)
  // is exact for every x below 2^XW
  localparam int XW       = RATE_W + MS_W;
  localparam int RECIP_W  = 27;
  localparam int RECIP_SH = 36;
  localparam logic [RECIP_W-1:0] RECIP = 27'd68719477;
  localparam int PROD_W   = XW + RECIP_W;
  localparam int QW       = PROD_W - RECIP_SH;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 2'd0,
    REQ_CREATE = 2'd1,
    REQ_RESET  = 2'd2,
    REQ_STOP   = 2'd3
  } req_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_IDLE    = 2'd0,
    KIND_FIRE    = 2'd1,
    KIND_CREATED = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  // operation broadcast to every cell in a cycle
  typedef enum logic [2:0] {
    CELL_NOP     = 3'd0,
    CELL_TICK    = 3'd1,
    CELL_CREATE  = 3'd2,
    CELL_RESTART = 3'd3,
    CELL_STOP    = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic                      paused;
    logic                      hold;
    logic signed [LOOP_W-1:0]  loop;
  } cell_cmd_t;

  typedef struct packed {
    logic live;
    logic fire;
  } cell_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/tmb_period.sv =====
// tmb_period: two-stage converter from a delay in ms to a period in ticks
// (rate * ms / 1000, saturated). Depends on tmb_pkg.
`default_nettype none

module tmb_period #(
  parameter int COUNT_WIDTH = tmb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic [tmb_pkg::RATE_W-1:0]  tick_rate,
  input  logic [tmb_pkg::MS_W-1:0]    period_ms,
  output logic [COUNT_WIDTH-1:0]      period
);
  import tmb_pkg::*;

  localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

  logic [XW-1:0]     x_r;
  logic [QW-1:0]     q_r;
  logic              zero_a_r;
  logic              zero_b_r;
  logic [PROD_W-1:0] prod;
  logic [32:0]       q_wide;

  // stage one: rate times delay
  always_ff @(posedge clk) begin
    x_r      <= XW'(tick_rate) * XW'(period_ms);
    zero_a_r <= (period_ms == '0);
  end

  // stage two: reciprocal multiply, keep the quotient bits
  assign prod = PROD_W'(x_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    q_r      <= prod[RECIP_SH +: QW];
    zero_b_r <= zero_a_r;
  end

  // saturate to the counter width, zero delay gives one tick
  assign q_wide = 33'(q_r);

  always_comb begin
    if (zero_b_r) begin
      period = COUNT_WIDTH'(1);
    end else if (q_wide > CNT_MAX) begin
      period = CNT_MAX[COUNT_WIDTH-1:0];
    end else begin
      period = q_wide[COUNT_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tmb_cell.sv =====
// tmb_cell: one timer slot of the chain, with its own count, period and
// repeat state, and a visit token handed to the next cell. Depends on tmb_pkg.
`default_nettype none

module tmb_cell #(
  parameter int COUNT_WIDTH = tmb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    tok_in,
  input  logic                    sel,
  input  tmb_pkg::cell_cmd_t      cmd,
  input  logic [COUNT_WIDTH-1:0]  period_in,
  output logic                    tok_out,
  output tmb_pkg::cell_stat_t     stat
);
  import tmb_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                      live_r,   live_nxt;
  logic                      tok_r,    tok_nxt;
  logic [COUNT_WIDTH-1:0]    period_r, period_nxt;
  logic [COUNT_WIDTH-1:0]    cnt_r,    cnt_nxt;
  logic signed [LOOP_W-1:0]  rset_r,   rset_nxt;
  logic signed [LOOP_W-1:0]  rleft_r,  rleft_nxt;
  logic                      hold_r,   hold_nxt;
  logic                      done_r,   done_nxt;

  logic [COUNT_WIDTH-1:0]    cnt_inc;
  logic signed [LOOP_W-1:0]  rdec;
  logic                      act;
  logic                      hit;

  // saturating count step and expiry test
  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + COUNT_WIDTH'(1);
  assign rdec    = rleft_r - LOOP_W'(1);
  assign act     = live_r & ~done_r & ~(hold_r & cmd.paused);
  assign hit     = tok_r & act & (cnt_inc >= period_r);

  always_comb begin
    live_nxt   = live_r;
    tok_nxt    = tok_r;
    period_nxt = period_r;
    cnt_nxt    = cnt_r;
    rset_nxt   = rset_r;
    rleft_nxt  = rleft_r;
    hold_nxt   = hold_r;
    done_nxt   = done_r;
    unique case (cmd.op)
      CELL_TICK: begin
        tok_nxt = tok_in;
        if (tok_r && act) begin
          cnt_nxt = cnt_inc;
          if (hit) begin
            cnt_nxt = '0;
            if (!rset_r[LOOP_W-1]) begin
              // counted timer finishes once repeats run out
              rleft_nxt = rdec;
              done_nxt  = rdec[LOOP_W-1];
            end else begin
              rleft_nxt = rset_r;
              done_nxt  = 1'b0;
            end
          end
        end
      end
      CELL_CREATE: begin
        if (sel) begin
          live_nxt   = 1'b1;
          period_nxt = period_in;
          cnt_nxt    = '0;
          rset_nxt   = cmd.loop;
          rleft_nxt  = cmd.loop;
          hold_nxt   = cmd.hold;
          done_nxt   = 1'b0;
        end
      end
      CELL_RESTART: begin
        if (sel && live_r) begin
          cnt_nxt   = '0;
          rleft_nxt = rset_r;
          done_nxt  = 1'b0;
        end
      end
      CELL_STOP: begin
        if (sel && live_r) begin
          cnt_nxt   = period_r;
          rleft_nxt = rset_r;
          done_nxt  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      live_r <= live_nxt;
      tok_r  <= tok_nxt;
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    period_r <= period_nxt;
    cnt_r    <= cnt_nxt;
    rset_r   <= rset_nxt;
    rleft_r  <= rleft_nxt;
    hold_r   <= hold_nxt;
    done_r   <= done_nxt;
  end

  assign tok_out   = tok_r;
  assign stat.live = live_r;
  assign stat.fire = hit;

endmodule

`default_nettype wire

// ===== rtl/core/multi_channel_tick_timer_bank.sv =====
// multi_channel_tick_timer_bank: top level with request sequencer, chain of
// timer cells, period converter and result register.
// Depends on tmb_pkg, tmb_period and tmb_cell.
//
//   port group | direction | handshake          | beat carries
//   in_*       | input     | in_valid/in_ready  | one request
//   out_*      | output    | out_valid/out_ready| one result
//   cfg_*      | input     | cfg_wr_en only     | tick rate
//
// On a tick a visit token walks the cell chain one slot a cycle, and S_FINISH
// flushes the final fire or the idle result. Create passes S_CALC_A, S_CALC_B
// (two multiplier stages); reset and stop use S_ADDR, a firing stop also
// S_STOP_DONE. A stalled result register holds the token walk until it drains.
// Reset is synchronous and clears all slots to not live and next slot to 0.
`default_nettype none

module multi_channel_tick_timer_bank #(
  parameter int NUM_TIMERS  = tmb_pkg::NUM_TIMERS_DEF,
  parameter int COUNT_WIDTH = tmb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [tmb_pkg::RATE_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tmb_pkg::REQ_W-1:0]         in_req_type,
  input  logic [tmb_pkg::ID_W-1:0]          in_timer_id,
  input  logic [tmb_pkg::MS_W-1:0]          in_period_ms,
  input  logic signed [tmb_pkg::LOOP_W-1:0] in_loop_count,
  input  logic                              in_pause_sensitive,
  input  logic                              in_fire_on_stop,
  input  logic                              in_paused,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tmb_pkg::KIND_W-1:0]        out_result_kind,
  output logic [tmb_pkg::ID_W-1:0]          out_timer_id_res,
  output logic                              out_found,
  output logic                              out_last
);
  import tmb_pkg::*;

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_SWEEP     = 8'b0000_0010,
    S_FINISH    = 8'b0000_0100,
    S_CALC_A    = 8'b0000_1000,
    S_CALC_B    = 8'b0001_0000,
    S_CREATE    = 8'b0010_0000,
    S_ADDR      = 8'b0100_0000,
    S_STOP_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [RATE_W-1:0]         rate_r;
  req_t                      req_r;
  logic [ID_W-1:0]           id_r;
  logic [MS_W-1:0]           ms_r;
  logic signed [LOOP_W-1:0]  loop_r;
  logic                      ps_r;
  logic                      fos_r;
  logic                      paused_r;

  logic [IW-1:0]             idx_r, idx_nxt;
  logic [IW-1:0]             next_slot_r, next_slot_nxt;
  logic                      pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]           pend_id_r, pend_id_nxt;

  logic                      out_valid_r;
  kind_t                     out_kind_r;
  logic [ID_W-1:0]           out_id_r;
  logic                      out_found_r;
  logic                      out_last_r;

  logic                      push;
  kind_t                     push_kind;
  logic [ID_W-1:0]           push_id;
  logic                      push_found;
  logic                      push_last;

  logic                      in_acc;
  logic                      out_free;
  logic                      inject;
  cell_cmd_t                 cmd;
  logic [NUM_TIMERS-1:0]     sel_vec;
  logic [NUM_TIMERS-1:0]     sel_create;
  logic [NUM_TIMERS-1:0]     sel_addr;
  logic [NUM_TIMERS-1:0]     tok_vec;
  logic [NUM_TIMERS-1:0]     live_vec;
  logic [NUM_TIMERS-1:0]     fire_vec;
  logic                      live_addr;
  logic                      fire_any;
  logic [COUNT_WIDTH-1:0]    period;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  // tick rate register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RST;
    end else if (cfg_wr_en) begin
      rate_r <= cfg_wr_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r    <= req_t'(in_req_type);
      id_r     <= in_timer_id;
      ms_r     <= in_period_ms;
      loop_r   <= in_loop_count;
      ps_r     <= in_pause_sensitive;
      fos_r    <= in_fire_on_stop;
      paused_r <= in_paused;
    end
  end

  // delay to ticks
  tmb_period #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_period (
    .clk       (clk),
    .tick_rate (rate_r),
    .period_ms (ms_r),
    .period    (period)
  );

  // slot decode for create and for reset or stop
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_sel
    assign sel_create[i] = (next_slot_r == IW'(i));
    assign sel_addr[i]   = (32'(id_r) == i);
  end

  assign live_addr = |(sel_addr & live_vec);
  assign fire_any  = |fire_vec;

  // chain of timer cells, token enters at slot 0
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    cell_stat_t st;
    logic       tin;

    if (i == 0) begin : g_head
      assign tin = inject;
    end else begin : g_link
      assign tin = tok_vec[i-1];
    end

    tmb_cell #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tok_in    (tin),
      .sel       (sel_vec[i]),
      .cmd       (cmd),
      .period_in (period),
      .tok_out   (tok_vec[i]),
      .stat      (st)
    );

    assign live_vec[i] = st.live;
    assign fire_vec[i] = st.fire;
  end

  // request sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd.op        = CELL_NOP;
    cmd.paused    = paused_r;
    cmd.hold      = ps_r;
    cmd.loop      = loop_r;
    sel_vec       = '0;
    inject        = 1'b0;
    idx_nxt       = idx_r;
    next_slot_nxt = next_slot_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    push          = 1'b0;
    push_kind     = KIND_IDLE;
    push_id       = '0;
    push_found    = 1'b0;
    push_last     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (req_t'(in_req_type))
            REQ_TICK: begin
              cmd.op    = CELL_TICK;
              inject    = 1'b1;
              idx_nxt   = '0;
              state_nxt = S_SWEEP;
            end
            REQ_CREATE: state_nxt = S_CALC_A;
            REQ_RESET:  state_nxt = S_ADDR;
            REQ_STOP:   state_nxt = S_ADDR;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_SWEEP: begin
        // one slot per beat slot; the previous fire goes out when a new one shows
        if (out_free) begin
          cmd.op  = CELL_TICK;
          idx_nxt = idx_r + IW'(1);
          if (fire_any) begin
            if (pend_v_r) begin
              push       = 1'b1;
              push_kind  = KIND_FIRE;
              push_id    = pend_id_r;
              push_found = 1'b1;
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = ID_W'(idx_r);
          end
          if (tok_vec[NUM_TIMERS-1]) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          if (pend_v_r) begin
            push_kind  = KIND_FIRE;
            push_id    = pend_id_r;
            push_found = 1'b1;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      S_CALC_A: state_nxt = S_CALC_B;
      S_CALC_B: state_nxt = S_CREATE;
      S_CREATE: begin
        if (out_free) begin
          cmd.op    = CELL_CREATE;
          sel_vec   = sel_create;
          push      = 1'b1;
          push_kind = KIND_CREATED;
          push_id   = ID_W'(next_slot_r);
          push_last = 1'b1;
          if (next_slot_r == IW'(NUM_TIMERS - 1)) begin
            next_slot_nxt = '0;
          end else begin
            next_slot_nxt = next_slot_r + IW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      S_ADDR: begin
        if (out_free) begin
          push    = 1'b1;
          push_id = id_r;
          if (req_r == REQ_STOP && fos_r && live_addr) begin
            // stop with fire: fire beat first
            push_kind  = KIND_FIRE;
            push_found = 1'b1;
            state_nxt  = S_STOP_DONE;
          end else begin
            cmd.op     = (req_r == REQ_RESET) ? CELL_RESTART : CELL_STOP;
            sel_vec    = sel_addr;
            push_kind  = KIND_DONE;
            push_found = live_addr;
            push_last  = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_STOP_DONE: begin
        if (out_free) begin
          cmd.op     = CELL_STOP;
          sel_vec    = sel_addr;
          push       = 1'b1;
          push_kind  = KIND_DONE;
          push_id    = id_r;
          push_found = 1'b1;
          push_last  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_slot_r <= '0;
      pend_v_r    <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      next_slot_r <= next_slot_nxt;
      pend_v_r    <= pend_v_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r <= pend_id_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_kind_r  <= push_kind;
      out_id_r    <= push_id;
      out_found_r <= push_found;
      out_last_r  <= push_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_timer_id_res = out_id_r;
  assign out_found        = out_found_r;
  assign out_last         = out_last_r;

`ifndef NO_ASSERTIONS
  // never more than one slot visited at a time
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one cell holds the visit token");

  // token only travels during a sweep
  a_tok_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (tok_vec == '0))
    else $error("visit token left in the chain while idle");

  // a held fire only exists while a tick is being worked
  a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (state_r == S_SWEEP || state_r == S_FINISH))
    else $error("pending fire outside a tick");

  // a created slot is live afterwards
  a_create_live: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == CELL_CREATE) |=> ((live_vec & $past(sel_create)) != '0))
    else $error("created slot not live");
`endif

endmodule

`default_nettype wire
